>>> rtl/core/decimal96_add_sub_defines.svh
// Assertion macros shared by the decimal add/subtract block.
`ifndef DECIMAL96_ADD_SUB_DEFINES_SVH
`define DECIMAL96_ADD_SUB_DEFINES_SVH
`ifndef SYNTHESIS
`define D96_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define D96_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define D96_ASSERT(label, clk, rst, prop, msg)
`define D96_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/d96_pkg.sv
package d96_pkg;
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_POS_OVF = 2'd1;
  localparam logic [1:0] STATUS_NEG_OVF = 2'd2;
  localparam int unsigned TEN = 10;
endpackage

>>> rtl/core/d96_div10.sv
// Divides by ten sixteen bits per cycle, most significant chunk first. Each
// chunk joined with the running remainder is divided by a reciprocal multiply,
// and the quotient is rounded half to even on the final remainder.
module d96_div10 #(
  parameter int unsigned MANTISSA_BITS = 96
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [MANTISSA_BITS-1:0] dividend,
  output logic                     done,
  output logic [MANTISSA_BITS-1:0] quotient
);
  localparam int unsigned CHUNK = 16;
  localparam int unsigned STEPS = (MANTISSA_BITS + CHUNK - 1) / CHUNK;
  localparam int unsigned PW = STEPS * CHUNK;
  localparam int unsigned CW = $clog2(STEPS + 1);
  // Rounded-up 2^23 / 10; exact for every partial dividend below 2^22.
  localparam logic [19:0] RECIP = 20'd838861;

  logic [PW-1:0] shreg;
  logic [PW-1:0] q;
  logic [PW-1:0] q_round;
  logic [3:0]    rem;
  logic [CW-1:0] count;
  logic          busy;
  logic [19:0]   partial;
  logic [39:0]   product;
  logic [15:0]   digit;
  logic [19:0]   back;
  logic [3:0]    rem_next;
  logic          round_up;

  // The remainder is below ten, so the partial dividend stays below 10 * 2^16.
  assign partial = {rem, shreg[PW-1 -: CHUNK]};
  assign product = 40'(partial) * 40'(RECIP);
  assign digit = 16'(product >> 23);
  assign back = 20'(digit) * 20'(d96_pkg::TEN);
  assign rem_next = 4'(partial - back);
  assign round_up = (rem > 4'd5) || (rem == 4'd5 && q[0]);
  assign q_round = q + PW'(round_up);
  assign quotient = q_round[MANTISSA_BITS-1:0];
  assign done = busy && count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CW'(STEPS);
    end else if (busy) begin
      if (count == '0) begin
        busy <= 1'b0;
      end else begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= PW'(dividend);
      q <= '0;
      rem <= '0;
    end else if (busy && count != '0) begin
      shreg <= shreg << CHUNK;
      q <= {q[PW-CHUNK-1:0], digit};
      rem <= rem_next;
    end
  end

  `include "decimal96_add_sub_defines.svh"
  `D96_ASSERT(a_rem_small, clk, rst, busy |-> rem < 4'(d96_pkg::TEN), "remainder reached ten")
  `D96_ASSERT(a_start_idle, clk, rst, start |-> !busy, "divider restarted while busy")
  `D96_ASSERT(a_done_ends, clk, rst, done |=> !busy, "divider stayed busy after done")
endmodule

>>> rtl/core/decimal96_add_sub.sv
// Alignment: each scale step multiplies the smaller-scale operand by ten or, when
// its top four bits are not clear, divides the other operand by ten; the final add
// or subtract is then written into the result register.
// Throughput: one transaction at a time; s_tready is low from acceptance until the
// sequencer is idle again, while a finished result may still wait at the output.
// Reset: rst is synchronous, active high; clears the sequencer and output valid.
module decimal96_add_sub #(
  parameter int unsigned MANTISSA_BITS = 96,
  parameter int unsigned MAX_SCALE = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[0], a_low[64:1], a_high[96:65], a_scale[101:97], a_negative[102],
  // b_low[166:103], b_high[198:167], b_scale[203:199], b_negative[204]
  input  logic [207:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_low[63:0], result_high[95:64], result_scale[100:96],
  // result_negative[101], status[103:102]
  output logic [103:0] m_tdata
);
  localparam int unsigned MB = MANTISSA_BITS;
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ALIGN = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_SUM   = 2'd3;
  localparam logic [5:0] MAXS = 6'(MAX_SCALE);

  logic [1:0]    state;
  logic [MB-1:0] a, b;
  logic [4:0]    sa, sb;
  logic          neg_a, neg_b, div_a;
  logic          div_start, div_done;
  logic [MB-1:0] div_in, div_q;
  logic [127:0]  a_full, b_full;
  logic [4:0]    sa_in, sb_in;
  logic          out_free;

  assign a_full = {32'd0, s_tdata[96:1]};
  assign b_full = {32'd0, s_tdata[198:103]};
  assign sa_in = ({1'b0, s_tdata[101:97]} > MAXS) ? 5'(MAXS) : s_tdata[101:97];
  assign sb_in = ({1'b0, s_tdata[203:199]} > MAXS) ? 5'(MAXS) : s_tdata[203:199];

  logic          a_small, small_top_clear;
  logic [MB-1:0] small_val, small_x10;
  assign a_small = sa < sb;
  assign small_val = a_small ? a : b;
  assign small_top_clear = small_val[MB-1 -: 4] == 4'd0;
  assign small_x10 = (small_val << 3) + (small_val << 1);

  // The output register frees up in the same cycle its transaction is taken.
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == ST_IDLE;
  assign div_in = a_small ? b : a;
  assign div_start = state == ST_ALIGN && sa != sb && !small_top_clear;

  d96_div10 #(.MANTISSA_BITS(MB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in),
    .done(div_done), .quotient(div_q)
  );

  logic [MB:0]   sum;
  logic          a_lt_b;
  assign sum = {1'b0, a} + {1'b0, b};
  assign a_lt_b = a < b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_SUM && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (s_tvalid && s_tready) state <= ST_ALIGN;
        ST_ALIGN: begin
          if (sa == sb) state <= ST_SUM;
          else if (!small_top_clear) state <= ST_DIV;
        end
        ST_DIV: if (div_done) state <= ST_ALIGN;
        ST_SUM: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        a <= a_full[MB-1:0];
        b <= b_full[MB-1:0];
        sa <= sa_in;
        sb <= sb_in;
        neg_a <= s_tdata[102];
        neg_b <= s_tdata[204] ^ s_tdata[0];
      end
      ST_ALIGN: begin
        div_a <= !a_small;
        if (sa != sb && small_top_clear) begin
          if (a_small) begin
            a <= small_x10;
            sa <= sa + 5'd1;
          end else begin
            b <= small_x10;
            sb <= sb + 5'd1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_a) begin
            a <= div_q;
            sa <= sa - 5'd1;
          end else begin
            b <= div_q;
            sb <= sb - 5'd1;
          end
        end
      end
      ST_SUM: begin
        if (out_free) begin
          m_tdata[100:96] <= sa;
          if (neg_a == neg_b) begin
            if (sum[MB]) begin
              m_tdata[95:0] <= '0;
              m_tdata[101] <= 1'b0;
              m_tdata[103:102] <= neg_a ? d96_pkg::STATUS_NEG_OVF : d96_pkg::STATUS_POS_OVF;
            end else begin
              m_tdata[95:0] <= 96'(sum[MB-1:0]);
              m_tdata[101] <= neg_a;
              m_tdata[103:102] <= d96_pkg::STATUS_OK;
            end
          end else if (a_lt_b) begin
            m_tdata[95:0] <= 96'(b - a);
            m_tdata[101] <= neg_b;
            m_tdata[103:102] <= d96_pkg::STATUS_OK;
          end else begin
            m_tdata[95:0] <= 96'(a - b);
            m_tdata[101] <= (a == b) ? 1'b0 : neg_a;
            m_tdata[103:102] <= d96_pkg::STATUS_OK;
          end
        end
      end
      default: ;
    endcase
  end

  `include "decimal96_add_sub_defines.svh"
  `D96_ASSERT(a_no_accept_busy, clk, rst, state != ST_IDLE |-> !s_tready, "ready while busy")
  `D96_ASSERT(a_scale_range, clk, rst, state == ST_ALIGN |-> {1'b0, sa} <= MAXS && {1'b0, sb} <= MAXS, "scale out of range")
  `D96_ASSERT(a_valid_after_sum, clk, rst, state == ST_SUM && out_free |=> m_tvalid, "result not presented")
  `D96_ASSERT(a_status_code, clk, rst, m_tvalid |-> m_tdata[103:102] != 2'd3, "bad status code")
endmodule

>>> dv/decimal96_add_sub_checker.sv
`timescale 1ns / 1ps
module decimal96_add_sub_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [207:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  output int           fail_count,
  output int           pending_count,
  output int           result_count,
  output int           overflow_count
);
  localparam int unsigned MAX_SC = 28;

  typedef struct packed {
    logic [1:0]  status;
    logic        negative;
    logic [4:0]  scale;
    logic [95:0] mantissa;
  } sum_t;

  sum_t expected_sums[$];

  function automatic logic [95:0] div_ten_even(logic [95:0] x);
    logic [95:0] q;
    logic [96:0] t;
    int unsigned r;
    q = x / 96'd10;
    r = int'(x % 96'd10);
    t = {1'b0, q};
    if (r > 5 || (r == 5 && q[0])) begin
      t = t + 97'd1;
    end
    return t[95:0];
  endfunction

  function automatic sum_t predict_sum(logic [207:0] d);
    sum_t s;
    logic [95:0] ma, mb;
    logic [96:0] total;
    logic [4:0] sa, sb;
    logic na, nb;
    ma = d[96:1];
    mb = d[198:103];
    sa = d[101:97];
    sb = d[203:199];
    if (sa > MAX_SC) sa = 5'(MAX_SC);
    if (sb > MAX_SC) sb = 5'(MAX_SC);
    na = d[102];
    nb = d[204] ^ d[0];
    while (sa > sb) begin
      if (mb[95:92] == 4'd0) begin
        mb = mb * 96'd10;
        sb++;
      end else begin
        ma = div_ten_even(ma);
        sa--;
      end
    end
    while (sb > sa) begin
      if (ma[95:92] == 4'd0) begin
        ma = ma * 96'd10;
        sa++;
      end else begin
        mb = div_ten_even(mb);
        sb--;
      end
    end
    s.scale = sa;
    s.status = d96_pkg::STATUS_OK;
    if (na == nb) begin
      total = {1'b0, ma} + {1'b0, mb};
      s.mantissa = total[95:0];
      s.negative = na;
      if (total[96]) begin
        s.status = na ? d96_pkg::STATUS_NEG_OVF : d96_pkg::STATUS_POS_OVF;
        s.mantissa = '0;
        s.negative = 1'b0;
      end
    end else if (ma < mb) begin
      s.mantissa = mb - ma;
      s.negative = nb;
    end else begin
      s.mantissa = ma - mb;
      s.negative = (ma == mb) ? 1'b0 : na;
    end
    return s;
  endfunction

  always @(posedge clk) begin
    sum_t want;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      overflow_count <= 0;
      pending_count <= 0;
      expected_sums.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        expected_sums.push_back(predict_sum(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        result_count <= result_count + 1;
        if (expected_sums.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_tdata);
          errs++;
        end else begin
          want = expected_sums.pop_front();
          if (want.status != d96_pkg::STATUS_OK) overflow_count <= overflow_count + 1;
          if (m_tdata[63:0] != want.mantissa[63:0]) begin
            $error("result_low: expected %h, actual %h", want.mantissa[63:0], m_tdata[63:0]);
            errs++;
          end
          if (m_tdata[95:64] != want.mantissa[95:64]) begin
            $error("result_high: expected %h, actual %h", want.mantissa[95:64],
                   m_tdata[95:64]);
            errs++;
          end
          if (m_tdata[100:96] != want.scale) begin
            $error("result_scale: expected %0d, actual %0d", want.scale, m_tdata[100:96]);
            errs++;
          end
          if (m_tdata[101] != want.negative) begin
            $error("result_negative: expected %0d, actual %0d", want.negative, m_tdata[101]);
            errs++;
          end
          if (m_tdata[103:102] != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tdata[103:102]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending_count <= expected_sums.size();
    end
  end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT = 2000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [207:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;
  int fail_count, pending_count, result_count, overflow_count;
  int idle_cycles;
  int sent_count;

  decimal96_add_sub dut (.*);

  decimal96_add_sub_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  function automatic logic [95:0] random_mantissa();
    logic [95:0] m;
    m = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      0: m = m >> $urandom_range(0, 95);
      1: m = m & 96'hFF;
      2: m = '1 - {88'd0, m[7:0]};
      3: m = m >> 4;
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] random_scale();
    if ($urandom_range(0, 9) == 0) return 5'($urandom_range(29, 31));
    return 5'($urandom_range(0, 28));
  endfunction

  function automatic logic [207:0] pack_item(logic cmd, logic [95:0] ma, logic [4:0] sa,
                                             logic na, logic [95:0] mb, logic [4:0] sb,
                                             logic nb);
    return {3'b000, nb, sb, mb, na, sa, ma, cmd};
  endfunction

  // s_tvalid stays high into the next transaction when there is no gap.
  task automatic send_item(logic [207:0] item);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  // Output stalls run on their own, with long stall-free stretches.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 3) == 0) begin
        stall = gap_length();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 200)) @(posedge clk);
    end
  end

  initial begin
    logic [95:0] all_ones;
    all_ones = '1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Zeros and signs, including two negative zeros and an exact cancel.
    send_item(pack_item(1'b0, 96'd0, 5'd0, 1'b0, 96'd0, 5'd0, 1'b0));
    send_item(pack_item(1'b0, 96'd0, 5'd0, 1'b1, 96'd0, 5'd0, 1'b1));
    send_item(pack_item(1'b1, 96'd0, 5'd5, 1'b1, 96'd0, 5'd3, 1'b0));
    send_item(pack_item(1'b1, 96'd1234, 5'd2, 1'b0, 96'd1234, 5'd2, 1'b0));
    send_item(pack_item(1'b0, 96'd1234, 5'd2, 1'b1, 96'd1234, 5'd2, 1'b0));
    // Overflow both ways, and a near miss.
    send_item(pack_item(1'b0, all_ones, 5'd0, 1'b0, 96'd1, 5'd0, 1'b0));
    send_item(pack_item(1'b1, all_ones, 5'd28, 1'b1, all_ones, 5'd28, 1'b0));
    send_item(pack_item(1'b0, all_ones, 5'd0, 1'b0, 96'd0, 5'd0, 1'b0));
    send_item(pack_item(1'b1, all_ones, 5'd0, 1'b0, all_ones, 5'd0, 1'b0));
    // Scale alignment: multiply runs, forced divides, half to even ties.
    send_item(pack_item(1'b0, 96'd7, 5'd0, 1'b0, 96'd3, 5'd28, 1'b0));
    send_item(pack_item(1'b0, all_ones, 5'd0, 1'b0, 96'd15, 5'd1, 1'b0));
    send_item(pack_item(1'b0, all_ones, 5'd0, 1'b0, 96'd25, 5'd1, 1'b1));
    send_item(pack_item(1'b1, 96'd35, 5'd28, 1'b0, all_ones, 5'd0, 1'b1));
    send_item(pack_item(1'b0, all_ones, 5'd0, 1'b1, all_ones, 5'd28, 1'b1));
    send_item(pack_item(1'b1, 96'd1, 5'd28, 1'b0, all_ones >> 4, 5'd0, 1'b0));
    // Scales above the maximum are clamped.
    send_item(pack_item(1'b0, 96'd99, 5'd31, 1'b0, 96'd1, 5'd29, 1'b1));
    send_item(pack_item(1'b1, all_ones, 5'd30, 1'b1, 96'd5, 5'd0, 1'b1));
    send_item(pack_item(1'b0, 96'h8000_0000_0000_0000_0000_0000, 5'd14, 1'b0,
                        96'h8000_0000_0000_0000_0000_0000, 5'd14, 1'b0));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      logic [4:0] sa, sb;
      sa = random_scale();
      // Half the items get equal or nearby scales to keep runs short; the rest span the range.
      case ($urandom_range(0, 3))
        0: sb = sa;
        1: sb = (sa > 28) ? 5'd28 : 5'(($urandom_range(0, 3) + sa) % 29);
        default: sb = random_scale();
      endcase
      send_item(pack_item(1'($urandom_range(0, 1)), random_mantissa(), sa,
                          1'($urandom_range(0, 1)), random_mantissa(), sb,
                          1'($urandom_range(0, 1))));
    end
    s_tvalid <= 1'b0;
    while (result_count < sent_count) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("Covered %0d results, %0d of them overflows, with scales 0 to 31.",
             result_count, overflow_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A divide-heavy item may need a divide step for every scale level plus a long output stall.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule
